// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Holds the depth of the cell chain, command and status codes, and the
// structs passed between the top level and the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int unsigned CAPACITY = 16;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned RANK_W   = 16;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // Broadcast to every cell in the cycle a transaction is taken.
   typedef struct packed {
      logic                     ins_en;
      logic                     rem_en;
      logic signed [DATA_W-1:0] data;
      logic signed [RANK_W-1:0] rank;
   } cell_ctrl_type;

   // Contents of one cell as seen by its neighbors.
   typedef struct packed {
      logic                     valid;
      logic                     keep;
      logic signed [DATA_W-1:0] data;
      logic signed [RANK_W-1:0] rank;
   } cell_slot_type;

endpackage

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift array
// Compares its own rank with the broadcast rank and, per command, keeps its
// entry, loads the new entry, or takes the entry of a neighbor.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  cell_slot_type left_slot,
   input  cell_slot_type right_slot,
   output cell_slot_type slot
);

   logic                     valid_ff, valid_in;
   logic signed [DATA_W-1:0] data_ff,  data_in;
   logic signed [RANK_W-1:0] rank_ff,  rank_in;
   logic                     keep;

   // Entries of equal or smaller rank stay ahead of the new one.
   assign keep = valid_ff && (rank_ff <= ctrl.rank);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      rank_in  = rank_ff;
      if (ctrl.ins_en && !keep) begin
         if (left_slot.keep) begin
            valid_in = 1'b1;
            data_in  = ctrl.data;
            rank_in  = ctrl.rank;
         end else begin
            valid_in = left_slot.valid;
            data_in  = left_slot.data;
            rank_in  = left_slot.rank;
         end
      end else if (ctrl.rem_en) begin
         // advance toward the head
         valid_in = right_slot.valid;
         data_in  = right_slot.data;
         rank_in  = right_slot.rank;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      rank_ff <= rank_in;
   end

   assign slot.valid = valid_ff;
   assign slot.keep  = keep;
   assign slot.data  = data_ff;
   assign slot.rank  = rank_ff;

endmodule

// ===== src/stable_priority_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue: sorted priority queue with FIFO order on equal rank
// A chain of CAPACITY cells keeps the entries sorted by rank, smallest at
// the head; inserts and removes update all cells in the same cycle.
// ----------------------------------------------------------------------------
//  channel   ports                                          direction
//  command   start, busy, req_command, req_entry_data,      in  (busy out)
//            req_entry_rank
//  result    rsp_valid, rsp_removed_data, rsp_status        out
//
//  One command per cycle: every cell compares its rank with the broadcast
//  rank in parallel and shifts in the same cycle, so busy stays low.
//  The result is registered and appears in the cycle after the command, for one cycle only.
//  Reset clears all valid bits; the queue is then empty.
//  The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module stable_priority_queue
   import spq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_command,
   input  logic signed [DATA_W-1:0] req_entry_data,
   input  logic signed [RANK_W-1:0] req_entry_rank,
   output logic                     rsp_valid,
   output logic signed [DATA_W-1:0] rsp_removed_data,
   output logic [1:0]               rsp_status
);

   cell_ctrl_type            ctrl;
   cell_slot_type            slots [CAPACITY];
   cell_slot_type            head_left;
   cell_slot_type            tail_right;
   logic [CAPACITY-1:0]      valid_vec;
   logic                     accept;
   logic                     is_remove;
   logic                     full;
   logic                     empty;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_data_ff,  rsp_data_in;
   status_type               rsp_status_ff, rsp_status_in;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign is_remove = (command_type'(req_command) == CMD_REMOVE);
   assign full      = slots[CAPACITY-1].valid;
   assign empty     = !slots[0].valid;

   assign ctrl.ins_en = accept && !is_remove && !full;
   assign ctrl.rem_en = accept && is_remove && !empty;
   assign ctrl.data   = req_entry_data;
   assign ctrl.rank   = req_entry_rank;

   // The head sees an always-kept neighbor, so a new entry lands there first.
   assign head_left  = '{valid: 1'b1, keep: 1'b1, data: '0, rank: '0};
   assign tail_right = '{valid: 1'b0, keep: 1'b0, data: '0, rank: '0};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .left_slot  ((i == 0) ? head_left : slots[(i == 0) ? 0 : i-1]),
         .right_slot ((i == CAPACITY-1) ? tail_right
                                        : slots[(i == CAPACITY-1) ? i : i+1]),
         .slot       (slots[i])
      );
      assign valid_vec[i] = slots[i].valid;
   end

   always_comb begin
      rsp_valid_in  = accept;
      rsp_data_in   = '0;
      rsp_status_in = STATUS_DONE;
      if (is_remove) begin
         if (empty) begin
            rsp_status_in = STATUS_EMPTY;
         end else begin
            rsp_data_in = slots[0].data;
         end
      end else if (full) begin
         rsp_status_in = STATUS_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_removed_data = rsp_data_ff;
   assign rsp_status       = rsp_status_ff;

   // Occupied cells always form a run starting at the head.
   assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + 1'b1)) == '0)
      else $error("occupied cells do not form a prefix");

   // A taken insert grows the queue by exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.ins_en |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
      else $error("insert did not add one entry");

   // A taken remove shrinks the queue by exactly one entry.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.rem_en |=> $countones(valid_vec) + 1 == $past($countones(valid_vec)))
      else $error("remove did not drop one entry");

   // Every accepted command yields a result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("missing result strobe");

   // Failed commands return zero data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status_ff != STATUS_DONE) |-> rsp_removed_data == '0)
      else $error("nonzero data on failed command");

endmodule
